// ===== hdl/eqbf_pkg.sv =====
// ----------------------------------------------------------------------------
// eqbf_pkg
// Shared constants and controller/datapath interface types for the equal
// block finder.
// ----------------------------------------------------------------------------
`default_nettype none

package eqbf_pkg;

  // Largest matrix side supported by the bitmap
  localparam int MaxSize = 8;
  // Coordinate width follows from the largest side
  localparam int CoordW  = $clog2(MaxSize);
  // Element and register widths
  localparam int DataW   = 32;
  localparam int SizeW   = 4;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMatrixSize = 2'd0,
    CfgWindowSize = 2'd1
  } eqbf_cfg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // store one request into the bitmap
    logic scan_init;    // start window scan at top row zero
    logic acc_step;     // AND one more bitmap row into the accumulator
    logic row_next;     // advance to the next candidate top row
    logic emit_pick;    // take lowest match of the current row
    logic finish_push;  // push final result of the run
  } eqbf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic load_wrap;    // current load position is the last of the matrix
    logic win_fits;     // window not larger than matrix
    logic acc_last;     // accumulator takes its last row this cycle
    logic hit_empty;    // no matches left in current row
    logic row_last;     // current top row is the last candidate
    logic pend_valid;   // a match is held back awaiting its last flag
    logic out_free;     // output register can take a result this cycle
  } eqbf_status_t;

endpackage

`default_nettype wire

// ===== hdl/equal_block_finder_core.sv =====
// ----------------------------------------------------------------------------
// equal_block_finder_core
// Finds all square windows where two loaded matrices agree element by element.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request per element
//   pair a_value_i/b_value_i, row-major over a matrix_size x matrix_size
//   matrix. Pairs are taken one per cycle while loading. The pair at the last
//   position starts the window scan; in_ready_o stays low until the scan
//   has pushed its final result.
//   Output channel (out_valid_o/out_ready_i) delivers one request per
//   matching window (top_row_o, left_col_o, found_o = 1) in row-major order;
//   the final one has last_result_o = 1. With no match, a single request
//   with found_o = 0, zero coordinates and last_result_o = 1 is sent.
//   Scan: per candidate top row, w bitmap rows (w window side) are ANDed,
//   one per cycle, then the row's matches are emitted; a final push ends
//   the run. A result waits in the output register while out_ready_i is
//   low; the scan holds at its next push until it is taken, and loading
//   resumes once the final result is registered. The user must write
//   configuration (cfg_we_i, cfg_idx_i, cfg_data_i) only while idle; the
//   block does not enforce it. Reset sets matrix_size = 8, window_size = 2
//   and the load position to the top-left corner; the bitmap is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module equal_block_finder_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [eqbf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [eqbf_pkg::SizeW-1:0]   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [eqbf_pkg::DataW-1:0] a_value_i,
  input  wire logic signed [eqbf_pkg::DataW-1:0] b_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [eqbf_pkg::CoordW-1:0]       top_row_o,
  output logic [eqbf_pkg::CoordW-1:0]       left_col_o,
  output logic                              found_o,
  output logic                              last_result_o
);
  import eqbf_pkg::*;

  eqbf_cmd_t    cmd;
  eqbf_status_t status;
  logic         in_ready;

  // Sequencer
  eqbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Bitmap, scan and output register
  eqbf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .a_value_i     (a_value_i),
    .b_value_i     (b_value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .top_row_o     (top_row_o),
    .left_col_o    (left_col_o),
    .found_o       (found_o),
    .last_result_o (last_result_o)
  );

  assign in_ready_o = in_ready;

endmodule

`default_nettype wire

// ===== hdl/eqbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// eqbf_ctrl
// Sequencer: load phase, row accumulation, match emission and final push.
// ----------------------------------------------------------------------------
`default_nettype none

module eqbf_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire eqbf_pkg::eqbf_status_t status_i,
  output eqbf_pkg::eqbf_cmd_t        cmd_o
);
  import eqbf_pkg::*;

  typedef enum logic [3:0] {
    StLoad   = 4'b0001,
    StAcc    = 4'b0010,
    StEmit   = 4'b0100,
    StFinish = 4'b1000
  } eqbf_state_e;

  eqbf_state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && status_i.load_wrap) begin
          if (status_i.win_fits) begin
            cmd_o.scan_init = 1'b1;
            state_d         = StAcc;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StAcc: begin
        cmd_o.acc_step = 1'b1;
        if (status_i.acc_last) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.hit_empty) begin
          if (status_i.row_last) begin
            state_d = StFinish;
          end else begin
            cmd_o.row_next = 1'b1;
            state_d        = StAcc;
          end
        end else if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.emit_pick = 1'b1;
        end
      end
      StFinish: begin
        if (status_i.out_free) begin
          cmd_o.finish_push = 1'b1;
          state_d           = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/eqbf_datapath.sv =====
// ----------------------------------------------------------------------------
// eqbf_datapath
// Config registers, equality bitmap, load counters, window scan and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eqbf_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [eqbf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [eqbf_pkg::SizeW-1:0]   cfg_data_i,
  input  wire logic [eqbf_pkg::DataW-1:0]   a_value_i,
  input  wire logic [eqbf_pkg::DataW-1:0]   b_value_i,
  input  wire eqbf_pkg::eqbf_cmd_t          cmd_i,
  output eqbf_pkg::eqbf_status_t            status_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [eqbf_pkg::CoordW-1:0]       top_row_o,
  output logic [eqbf_pkg::CoordW-1:0]       left_col_o,
  output logic                              found_o,
  output logic                              last_result_o
);
  import eqbf_pkg::*;

  localparam logic [SizeW-1:0] MaxSizeW = SizeW'(MaxSize);

  // Match vector of one top row: bit c set when the window at column c fits
  // and every column it covers has all ones in the vertical AND.
  function automatic logic [MaxSize-1:0] row_hits(logic [MaxSize-1:0] acc,
                                                  logic [SizeW-1:0] w,
                                                  logic [SizeW-1:0] s);
    logic [MaxSize-1:0] hits;
    logic               ok;
    hits = '0;
    for (int c = 0; c < MaxSize; c++) begin
      ok = ((c + int'(w)) <= int'(s));
      for (int y = 0; y < MaxSize; y++) begin
        if (y < int'(w)) begin
          if (c + y < MaxSize) begin
            ok = ok & acc[c + y];
          end else begin
            ok = 1'b0;
          end
        end
      end
      hits[c] = ok;
    end
    return hits;
  endfunction

  // Configuration registers
  logic [SizeW-1:0] matrix_size_q, window_size_q;
  logic [SizeW-1:0] s_eff, w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= MaxSizeW;
      window_size_q <= SizeW'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMatrixSize: matrix_size_q <= cfg_data_i;
        CfgWindowSize: window_size_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Clamp to supported ranges
  always_comb begin
    s_eff = matrix_size_q;
    if (s_eff == '0) begin
      s_eff = SizeW'(1);
    end else if (s_eff > MaxSizeW) begin
      s_eff = MaxSizeW;
    end
    w_eff = (window_size_q < SizeW'(2)) ? SizeW'(2) : window_size_q;
  end

  // Equality bitmap, one row word per matrix row
  logic [MaxSize-1:0] map_q [MaxSize];
  logic [CoordW-1:0]  load_row_q, load_col_q;
  logic               col_wrap, row_wrap;

  assign col_wrap = ({1'b0, load_col_q} + SizeW'(1)) >= s_eff;
  assign row_wrap = ({1'b0, load_row_q} + SizeW'(1)) >= s_eff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      map_q[load_row_q][load_col_q] <= (a_value_i == b_value_i);
    end
  end

  // Load position, row-major with wrap at the configured size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q <= '0;
      load_col_q <= '0;
    end else if (cmd_i.load) begin
      if (col_wrap) begin
        load_col_q <= '0;
        load_row_q <= row_wrap ? '0 : load_row_q + CoordW'(1);
      end else begin
        load_col_q <= load_col_q + CoordW'(1);
      end
    end
  end

  // Scan state
  logic [CoordW-1:0]  scan_row_q, acc_cnt_q;
  logic [CoordW-1:0]  acc_addr;
  logic [MaxSize-1:0] acc_q, acc_next, hit_q, pick_mask;
  logic [CoordW-1:0]  pick_col;
  logic               acc_last;

  assign acc_addr = scan_row_q + acc_cnt_q;
  assign acc_next = acc_q & map_q[acc_addr];
  assign acc_last = ({1'b0, acc_cnt_q} == (w_eff - SizeW'(1)));

  // Lowest remaining match of the current row
  always_comb begin
    pick_col  = '0;
    pick_mask = '0;
    for (int c = MaxSize - 1; c >= 0; c--) begin
      if (hit_q[c]) begin
        pick_col = CoordW'(c);
      end
    end
    pick_mask[pick_col] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= '0;
      acc_cnt_q  <= '0;
      acc_q      <= '1;
      hit_q      <= '0;
    end else begin
      if (cmd_i.scan_init) begin
        scan_row_q <= '0;
        acc_cnt_q  <= '0;
        acc_q      <= '1;
      end
      if (cmd_i.acc_step) begin
        if (acc_last) begin
          hit_q     <= row_hits(acc_next, w_eff, s_eff);
          acc_q     <= '1;
          acc_cnt_q <= '0;
        end else begin
          acc_q     <= acc_next;
          acc_cnt_q <= acc_cnt_q + CoordW'(1);
        end
      end
      if (cmd_i.row_next) begin
        scan_row_q <= scan_row_q + CoordW'(1);
      end
      if (cmd_i.emit_pick) begin
        hit_q <= hit_q & ~pick_mask;
      end
    end
  end

  // Held-back match: emitted once the next one or the end of the scan is seen
  logic              pend_valid_q;
  logic [CoordW-1:0] pend_row_q, pend_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.emit_pick) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.finish_push || cmd_i.scan_init) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pick) begin
      pend_row_q <= scan_row_q;
      pend_col_q <= pick_col;
    end
  end

  // Output register
  logic push;
  logic out_valid_q;

  assign push = (cmd_i.emit_pick && pend_valid_q) || cmd_i.finish_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (pend_valid_q) begin
        top_row_o  <= pend_row_q;
        left_col_o <= pend_col_q;
        found_o    <= 1'b1;
      end else begin
        top_row_o  <= '0;
        left_col_o <= '0;
        found_o    <= 1'b0;
      end
      last_result_o <= cmd_i.finish_push;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  always_comb begin
    status_o            = '0;
    status_o.load_wrap  = col_wrap && row_wrap;
    status_o.win_fits   = (w_eff <= s_eff);
    status_o.acc_last   = acc_last;
    status_o.hit_empty  = (hit_q == '0);
    status_o.row_last   = ({1'b0, scan_row_q} == (s_eff - w_eff));
    status_o.pend_valid = pend_valid_q;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  // A reported window lies inside the matrix
  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && found_o |-> ({1'b0, top_row_o} + w_eff <= s_eff) &&
                               ({1'b0, left_col_o} + w_eff <= s_eff))
    else $error("reported window outside matrix");

  // Not-found result closes the run with zero coordinates
  a_not_found_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_o |-> last_result_o && top_row_o == '0 &&
                                left_col_o == '0)
    else $error("malformed not-found result");

  // Pending match never overwritten without being pushed
  a_pend_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_pick && pend_valid_q |-> !out_valid_q || out_ready_i)
    else $error("held match dropped on full output");

  // Leftover row matches cleared before a new run starts
  a_hits_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_push |-> hit_q == '0 || !status_o.win_fits)
    else $error("run finished with matches left");

endmodule

`default_nettype wire

// ===== dv/eqbf_match_sb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqbf_match_sb_pkg
// Scoreboard for the equal block finder: mirrors the equality bitmap and load
// position, predicts the window hits of each completed matrix and checks them.
// ----------------------------------------------------------------------------

package eqbf_match_sb_pkg;

  import eqbf_pkg::*;

  // One window hit as seen on the output channel
  typedef struct packed {
    logic [CoordW-1:0] top_row;
    logic [CoordW-1:0] left_col;
    logic              found;
    logic              last_result;
  } window_hit_t;

  class window_match_sb;

    bit               eq_map [MaxSize*MaxSize];
    int unsigned      load_row;
    int unsigned      load_col;
    logic [SizeW-1:0] matrix_size;
    logic [SizeW-1:0] window_size;
    window_hit_t      hits_due [$];
    int unsigned      err_count;

    // State right after reset
    function new();
      foreach (eq_map[i]) eq_map[i] = 1'b0;
      load_row    = 0;
      load_col    = 0;
      matrix_size = 4'd8;
      window_size = 4'd2;
      err_count   = 0;
    endfunction

    function void write_cfg(eqbf_cfg_e idx, logic [SizeW-1:0] data);
      case (idx)
        CfgMatrixSize: matrix_size = data;
        CfgWindowSize: window_size = data;
        default: ;
      endcase
    endfunction

    // Matrix side as the block uses it: zero acts as one, clipped at the max
    function int unsigned side();
      if (matrix_size == 0) return 1;
      if (matrix_size > MaxSize) return MaxSize;
      return 32'(matrix_size);
    endfunction

    // Windows below two act as two
    function int unsigned win();
      return (window_size < 2) ? 2 : 32'(window_size);
    endfunction

    function bit window_ok(int unsigned r, int unsigned c, int unsigned w);
      for (int unsigned x = 0; x < w; x++)
        for (int unsigned y = 0; y < w; y++)
          if (!eq_map[(r + x) * MaxSize + c + y]) return 1'b0;
      return 1'b1;
    endfunction

    // Row-major window scan; the final hit is held back to get its last flag
    function void scan_map();
      int unsigned s;
      int unsigned w;
      window_hit_t prev;
      bit          have_prev;
      s         = side();
      w         = win();
      prev      = '0;
      have_prev = 1'b0;
      if (w <= s) begin
        for (int unsigned r = 0; r + w <= s; r++)
          for (int unsigned c = 0; c + w <= s; c++)
            if (window_ok(r, c, w)) begin
              if (have_prev) hits_due.push_back(prev);
              prev.top_row     = CoordW'(r);
              prev.left_col    = CoordW'(c);
              prev.found       = 1'b1;
              prev.last_result = 1'b0;
              have_prev        = 1'b1;
            end
      end
      // no match at all: single not-found request
      if (!have_prev) prev = '0;
      prev.last_result = 1'b1;
      hits_due.push_back(prev);
    endfunction

    // Accepted element pair: store equality bit, advance, scan on wrap
    function void note_request(logic [DataW-1:0] a, logic [DataW-1:0] b);
      int unsigned s;
      s = side();
      if (load_row < MaxSize && load_col < MaxSize)
        eq_map[load_row * MaxSize + load_col] = (a == b);
      if (load_col + 1 >= s) begin
        load_col = 0;
        if (load_row + 1 >= s) begin
          load_row = 0;
          scan_map();
        end else begin
          load_row++;
        end
      end else begin
        load_col++;
      end
    endfunction

    function void compare_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
        err_count++;
      end
    endfunction

    function void check_result(window_hit_t got);
      window_hit_t want;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got row %0d col %0d found %0b last %0b",
                 $time, got.top_row, got.left_col, got.found, got.last_result);
        err_count++;
        return;
      end
      want = hits_due.pop_front();
      compare_field("top_row", 32'(want.top_row), 32'(got.top_row));
      compare_field("left_col", 32'(want.left_col), 32'(got.left_col));
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
    endfunction

  endclass

endpackage

// ===== dv/equal_block_finder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_block_finder_core_tb
// Streams matrix pairs through the equal block finder under random sender
// bursts and receiver stalls, and checks every window hit against a scoreboard
// that tracks the equality bitmap. Covers size/window clamping, oversized
// windows, full-match matrices and output back-pressure.
// ----------------------------------------------------------------------------

module equal_block_finder_core_tb;

  import eqbf_pkg::*;
  import eqbf_match_sb_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 9;
  localparam int ItemTarget  = 420;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 400;
  localparam int IdleDrain   = 16;
  localparam int EndDrain    = 32;

  logic                    clk       = 1'b0;
  logic                    rst_ni    = 1'b0;
  logic                    cfg_we    = 1'b0;
  eqbf_cfg_e               cfg_idx   = CfgMatrixSize;
  logic [SizeW-1:0]        cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic signed [DataW-1:0] a_value   = '0;
  logic signed [DataW-1:0] b_value   = '0;
  logic                    out_ready = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic [CoordW-1:0]       top_row;
  logic [CoordW-1:0]       left_col;
  logic                    found;
  logic                    last_result;

  window_match_sb sb;

  int unsigned cycle_count   = 0;
  int          burst_left    = 0;
  int unsigned items_sent    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  bit          holding       = 1'b0;

  equal_block_finder_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .a_value_i     (a_value),
    .b_value_i     (b_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .top_row_o     (top_row),
    .left_col_o    (left_col),
    .found_o       (found),
    .last_result_o (last_result)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results pending", $time, sb.hits_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Handshake monitor: inputs first so a scan is predicted before its results
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_request(a_value, b_value);
      if (out_valid && out_ready)
        sb.check_result(window_hit_t'({top_row, left_col, found, last_result}));
    end
  end

  // Receiver: ready/stall runs, plus a long hold-off on request
  initial begin : receiver
    int on_len;
    int off_len;
    forever begin
      if (holds_served != hold_requests) begin
        out_ready <= 1'b0;
        holding = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        holding = 1'b0;
        holds_served++;
      end else begin
        on_len  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        off_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        out_ready <= 1'b1;
        repeat (on_len) @(posedge clk);
        if (off_len != 0) begin
          out_ready <= 1'b0;
          repeat (off_len) @(posedge clk);
        end
      end
    end
  end

  // Write both registers on consecutive cycles; block must be idle
  task automatic set_config(input logic [SizeW-1:0] ms, input logic [SizeW-1:0] ws);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgMatrixSize;
    cfg_data <= ms;
    @(posedge clk);
    cfg_idx  <= CfgWindowSize;
    cfg_data <= ws;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.write_cfg(CfgMatrixSize, ms);
    sb.write_cfg(CfgWindowSize, ws);
  endtask

  // Offer one element pair; bursts of random length separated by gaps
  task automatic push_pair(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    a_value  <= a;
    b_value  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait for every predicted hit, then let the block settle
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.hits_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Element value biased toward the extremes
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Percentage of equal positions in a matrix
  function automatic int pick_density();
    case ($urandom_range(0, 9))
      0, 1:       return 100;
      2, 3, 4, 5: return 90;
      6, 7:       return 60;
      8:          return 20;
      default:    return 0;
    endcase
  endfunction

  // One full matrix pair; unequal entries differ in one bit or at random
  task automatic send_matrix(input int unsigned side_len, input int eq_pct);
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    for (int unsigned i = 0; i < side_len * side_len; i++) begin
      a = pick_value();
      if ($urandom_range(1, 100) <= eq_pct) b = a;
      else if ($urandom_range(0, 1) == 1) b = a ^ (32'd1 << $urandom_range(0, 31));
      else b = pick_value();
      push_pair(a, b);
    end
  endtask

  // Configure, optionally hold the receiver off, stream matrices, drain
  task automatic run_phase(input logic [SizeW-1:0] ms, input logic [SizeW-1:0] ws,
                           input int nmat, input int eq_pct, input bit hold);
    set_config(ms, ws);
    if (hold) begin
      hold_requests++;
      while (!holding) @(posedge clk);
    end
    for (int m = 0; m < nmat; m++)
      send_matrix(sb.side(), (eq_pct < 0) ? pick_density() : eq_pct);
    drain(IdleDrain);
  endtask

  initial begin : stimulus
    logic [SizeW-1:0] ms;
    logic [SizeW-1:0] ws;
    int               r;
    sb = new();
    repeat (ResetCycles) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // 1x1 matrix, window below two: not found
    set_config(4'd1, 4'd1);
    push_pair(32'h8000_0000, 32'h8000_0000);
    drain(IdleDrain);
    // size zero acts as one, window zero as two
    set_config(4'd0, 4'd0);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain(IdleDrain);
    // 2x2 all equal at the extremes, then two single-bit differences
    set_config(4'd2, 4'd2);
    push_pair(32'h8000_0000, 32'h8000_0000);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_pair(32'h0000_0000, 32'h0000_0000);
    push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pair(32'h8000_0000, 32'h8000_0000);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_pair(32'h0000_0000, 32'h8000_0000);
    push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    drain(IdleDrain);
    // 3x3 with one mismatch at the top right: three of four windows hit
    set_config(4'd3, 4'd2);
    for (int i = 0; i < 9; i++)
      push_pair(i, (i == 2) ? (i ^ 32'h4000_0000) : i);
    drain(IdleDrain);

    // Corner settings: most hits, size clipped, back-pressure, oversized window
    run_phase(4'd8, 4'd2, 1, 100, 1'b0);
    run_phase(4'd15, 4'd8, 1, 100, 1'b0);
    run_phase(4'd3, 4'd2, 4, -1, 1'b1);
    run_phase(4'd4, 4'd15, 1, -1, 1'b0);

    // Random settings, mostly small matrices
    while (items_sent < ItemTarget) begin
      r = $urandom_range(0, 15);
      if (r < 10) ms = SizeW'($urandom_range(2, 5));
      else if (r < 13) ms = SizeW'($urandom_range(6, 8));
      else if (r == 13) ms = SizeW'($urandom_range(0, 1));
      else ms = SizeW'($urandom_range(9, 15));
      r = $urandom_range(0, 15);
      if (r < 9) ws = 4'd2;
      else if (r < 13) ws = SizeW'($urandom_range(3, 4));
      else if (r < 15) ws = SizeW'($urandom_range(5, 8));
      else ws = SizeW'($urandom_range(0, 15));
      run_phase(ms, ws, $urandom_range(1, 3), -1, 1'b0);
    end

    repeat (EndDrain) @(posedge clk);
    if (sb.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== equal_block_finder_core.f =====
hdl/eqbf_pkg.sv
hdl/eqbf_ctrl.sv
hdl/eqbf_datapath.sv
hdl/equal_block_finder_core.sv
dv/eqbf_match_sb_pkg.sv
dv/equal_block_finder_core_tb.sv
